// ===== src/ubsv_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 / BOM stream validator.
package ubsv_pkg;

  localparam int unsigned CountW           = 23;
  localparam int unsigned MaxSampleDefault = 4194304;
  localparam logic [CountW-1:0] SampleLimitReset = 23'h400000;

  // APB: one 32-bit register, byte addressed
  localparam int unsigned RegAddrW = 3;
  localparam int unsigned RegDataW = 32;

  // Front-to-back beat queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Byte values of the UTF-8 rules
  localparam logic [7:0] ByteAsciiTop = 8'h80;
  localparam logic [7:0] ByteLead2Lo  = 8'hC2;
  localparam logic [7:0] ByteLead2Hi  = 8'hDF;
  localparam logic [7:0] ByteLead3Lo  = 8'hE0;
  localparam logic [7:0] ByteLead3Hi  = 8'hEF;
  localparam logic [7:0] ByteLead4Lo  = 8'hF0;
  localparam logic [7:0] ByteLead4Hi  = 8'hF4;
  localparam logic [7:0] ByteContLo   = 8'h80;
  localparam logic [7:0] ByteContHi   = 8'hBF;
  localparam logic [7:0] ByteE0Min    = 8'hA0;
  localparam logic [7:0] ByteSurrLead = 8'hED;
  localparam logic [7:0] ByteSurrMin  = 8'hA0;
  localparam logic [7:0] ByteF0Min    = 8'h90;
  localparam logic [7:0] ByteF4Max    = 8'h8F;

  // BOM byte values
  localparam logic [7:0] BomEf = 8'hEF;
  localparam logic [7:0] BomBb = 8'hBB;
  localparam logic [7:0] BomBf = 8'hBF;
  localparam logic [7:0] BomFf = 8'hFF;
  localparam logic [7:0] BomFe = 8'hFE;

  localparam logic [1:0] BomLenNone  = 2'd0;
  localparam logic [1:0] BomLenUtf16 = 2'd2;
  localparam logic [1:0] BomLenUtf8  = 2'd3;

  typedef enum logic [1:0] {
    BOM_NONE,
    BOM_UTF8,
    BOM_UTF16LE,
    BOM_UTF16BE
  } bom_kind_e;

  typedef enum logic [2:0] {
    ENC_UNKNOWN     = 3'd0,
    ENC_UTF8_BOM    = 3'd1,
    ENC_UTF16LE_BOM = 3'd2,
    ENC_UTF16BE_BOM = 3'd3,
    ENC_UTF8        = 3'd4
  } enc_class_e;

  typedef enum logic [0:0] {
    REG_SAMPLE_LIMIT = 1'b0
  } reg_index_e;

  // One classified beat handed from front to back
  typedef struct packed {
    logic [7:0]        data;
    logic              examine;  // byte lies inside the sample
    logic              last;     // closes the buffer
    logic [CountW-1:0] seen;     // examined bytes, valid on last
    bom_kind_e         bom;      // BOM found in the head, valid on last
  } beat_t;

  // Continuation bytes a lead byte asks for; 0 = not a lead
  function automatic logic [1:0] lead_need(input logic [7:0] c);
    logic [1:0] n;
    n = 2'd0;
    if (c >= ByteLead2Lo && c <= ByteLead2Hi) n = 2'd1;
    else if (c >= ByteLead3Lo && c <= ByteLead3Hi) n = 2'd2;
    else if (c >= ByteLead4Lo && c <= ByteLead4Hi) n = 2'd3;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c >= ByteContLo) && (c <= ByteContHi);
  endfunction

  function automatic logic [1:0] bom_len(input bom_kind_e k);
    logic [1:0] l;
    unique case (k)
      BOM_UTF8:                 l = BomLenUtf8;
      BOM_UTF16LE, BOM_UTF16BE: l = BomLenUtf16;
      default:                  l = BomLenNone;
    endcase
    return l;
  endfunction

endpackage

// ===== src/ubsv_front.sv =====
// Front end: sample window, head capture and BOM classification per beat.
module ubsv_front #(
  parameter int unsigned MAX_SAMPLE = ubsv_pkg::MaxSampleDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ubsv_pkg::CountW-1:0] sample_limit_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_buffer_i,
  input  logic                        accept_i,
  output ubsv_pkg::beat_t             beat_o
);

  localparam int unsigned W = ubsv_pkg::CountW;
  localparam logic [W-1:0] MaxLim =
    (64'(MAX_SAMPLE) >= (64'd1 << W)) ? {W{1'b1}} : W'(MAX_SAMPLE);

  logic [W-1:0] seen_q, seen_d, seen_next, lim_eff;
  logic [7:0]   head_q [3];
  logic [7:0]   head_d [3];
  logic [7:0]   head_next [3];
  logic         examine;
  ubsv_pkg::bom_kind_e bom;

  always_comb begin
    if (sample_limit_i == '0) begin
      lim_eff = W'(1);
    end else if (sample_limit_i > MaxLim) begin
      lim_eff = MaxLim;
    end else begin
      lim_eff = sample_limit_i;
    end
    examine   = seen_q < lim_eff;
    seen_next = examine ? seen_q + W'(1) : seen_q;
    head_next = head_q;
    if (examine && seen_q < W'(3)) begin
      head_next[seen_q[1:0]] = data_byte_i;
    end

    priority if (seen_next >= W'(3) && head_next[0] == ubsv_pkg::BomEf &&
                 head_next[1] == ubsv_pkg::BomBb && head_next[2] == ubsv_pkg::BomBf) begin
      bom = ubsv_pkg::BOM_UTF8;
    end else if (seen_next >= W'(2) && head_next[0] == ubsv_pkg::BomFf &&
                 head_next[1] == ubsv_pkg::BomFe) begin
      bom = ubsv_pkg::BOM_UTF16LE;
    end else if (seen_next >= W'(2) && head_next[0] == ubsv_pkg::BomFe &&
                 head_next[1] == ubsv_pkg::BomFf) begin
      bom = ubsv_pkg::BOM_UTF16BE;
    end else begin
      bom = ubsv_pkg::BOM_NONE;
    end

    beat_o.data    = data_byte_i;
    beat_o.examine = examine;
    beat_o.last    = end_of_buffer_i;
    beat_o.seen    = seen_next;
    beat_o.bom     = bom;

    seen_d = seen_q;
    head_d = head_q;
    if (accept_i) begin
      if (end_of_buffer_i) begin
        seen_d = '0;
        head_d = '{default: 8'h00};
      end else begin
        seen_d = seen_next;
        head_d = head_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      head_q <= '{default: 8'h00};
    end else begin
      seen_q <= seen_d;
      head_q <= head_d;
    end
  end

endmodule

// ===== src/ubsv_fifo.sv =====
// Small beat queue between front and back end.
module ubsv_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ubsv_pkg::beat_t push_beat_i,
  output logic            ready_o,
  output logic            valid_o,
  output ubsv_pkg::beat_t beat_o,
  input  logic            pop_i
);

  localparam int unsigned PW = ubsv_pkg::QPtrW;
  localparam int unsigned CW = ubsv_pkg::QCntW;

  ubsv_pkg::beat_t mem_q [ubsv_pkg::QDepth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(ubsv_pkg::QDepth - 1)) ? '0 : p + PW'(1);
  endfunction

  assign ready_o = cnt_q != CW'(ubsv_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign beat_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

endmodule

// ===== src/ubsv_back.sv =====
// Back end: UTF-8 sequence checker with replay, invalid count and result register.
module ubsv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  ubsv_pkg::beat_t             q_beat_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  encoding_class_o,
  output logic [1:0]                  bom_length_o,
  output logic [ubsv_pkg::CountW-1:0] invalid_count_o,
  output logic                        strict_valid_o
);

  localparam int unsigned W  = ubsv_pkg::CountW;
  localparam int unsigned PW = W + 7;  // room for count * 100

  // pending sequence: lead plus up to two continuation bytes
  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];
  logic [1:0] need_q, need_d, fill_q, fill_d;
  // replay queue for bytes after a failed lead
  logic [7:0] rq_q [3];
  logic [7:0] rq_d [3];
  logic [1:0] rqn_q, rqn_d;
  logic [W-1:0] bad_q, bad_d;
  logic closing_q, closing_d;
  logic [W-1:0] cl_seen_q, cl_seen_d;
  ubsv_pkg::bom_kind_e cl_bom_q, cl_bom_d;
  logic out_valid_q, out_valid_d;
  ubsv_pkg::enc_class_e cls_q, cls_d;
  logic [1:0] bom_len_q, bom_len_d;
  logic [W-1:0] cnt_q, cnt_d;

  logic use_rq, take_q, step, complete, ok, bad_inc, do_close;
  logic [7:0] c, c1, lead;
  logic [1:0] cneed;
  logic [7:0] tail [3];
  logic [7:0] rest [2];
  logic [1:0] rest_n;
  logic [W-1:0] bad_fin;
  logic [PW-1:0] prod, thresh;

  always_comb begin
    use_rq   = rqn_q != 2'd0;
    take_q   = !use_rq && !closing_q && q_valid_i;
    step     = use_rq || (take_q && q_beat_i.examine);
    c        = use_rq ? rq_q[0] : q_beat_i.data;
    q_pop_o  = take_q;
    cneed    = ubsv_pkg::lead_need(c);
    lead     = pend_q[0];
    c1       = pend_q[1];
    complete = (fill_q != 2'd0) && (fill_q == need_q);

    ok = ubsv_pkg::is_cont(c);
    if (need_q >= 2'd2 && !ubsv_pkg::is_cont(pend_q[1])) ok = 1'b0;
    if (need_q == 2'd3 && !ubsv_pkg::is_cont(pend_q[2])) ok = 1'b0;
    if (need_q == 2'd2 && lead == ubsv_pkg::ByteLead3Lo && c1 < ubsv_pkg::ByteE0Min)
      ok = 1'b0;
    if (need_q == 2'd2 && lead == ubsv_pkg::ByteSurrLead && c1 >= ubsv_pkg::ByteSurrMin)
      ok = 1'b0;
    if (need_q == 2'd3 && lead == ubsv_pkg::ByteLead4Lo && c1 < ubsv_pkg::ByteF0Min)
      ok = 1'b0;
    if (need_q == 2'd3 && lead == ubsv_pkg::ByteLead4Hi && c1 > ubsv_pkg::ByteF4Max)
      ok = 1'b0;

    // bytes after the failed lead, the just-arrived byte being the last of them
    tail[0] = (need_q == 2'd1) ? c : pend_q[1];
    tail[1] = (need_q == 2'd2) ? c : pend_q[2];
    tail[2] = c;
    rest[0] = rq_q[1];
    rest[1] = rq_q[2];
    rest_n  = use_rq ? rqn_q - 2'd1 : 2'd0;

    pend_d    = pend_q;
    need_d    = need_q;
    fill_d    = fill_q;
    rq_d      = rq_q;
    rqn_d     = rqn_q;
    bad_inc   = 1'b0;
    closing_d = closing_q;
    cl_seen_d = cl_seen_q;
    cl_bom_d  = cl_bom_q;

    if (use_rq) begin
      rq_d[0] = rq_q[1];
      rq_d[1] = rq_q[2];
      rqn_d   = rest_n;
    end

    if (step) begin
      if (fill_q == 2'd0) begin
        if (c >= ubsv_pkg::ByteAsciiTop) begin
          if (cneed == 2'd0) begin
            bad_inc = 1'b1;
          end else begin
            pend_d[0] = c;
            need_d    = cneed;
            fill_d    = 2'd1;
          end
        end
      end else if (!complete) begin
        pend_d[fill_q] = c;
        fill_d         = fill_q + 2'd1;
      end else begin
        fill_d = 2'd0;
        if (!ok) begin
          bad_inc = 1'b1;
          rq_d[0] = tail[0];
          rq_d[1] = (need_q >= 2'd2) ? tail[1] : rest[0];
          rq_d[2] = (need_q == 2'd3) ? tail[2] :
                    ((need_q == 2'd2) ? rest[0] : rest[1]);
          rqn_d   = need_q + rest_n;
        end
      end
    end

    if (take_q && q_beat_i.last) begin
      closing_d = 1'b1;
      cl_seen_d = q_beat_i.seen;
      cl_bom_d  = q_beat_i.bom;
    end

    bad_d = (bad_inc && bad_q != {W{1'b1}}) ? bad_q + W'(1) : bad_q;

    // close: a cut-off sequence counts once, then classify
    do_close = closing_q && !use_rq && (!out_valid_q || out_ready_i);
    bad_fin  = (fill_q != 2'd0 && bad_q != {W{1'b1}}) ? bad_q + W'(1) : bad_q;
    prod     = {1'b0, bad_fin, 6'b0} + {2'b0, bad_fin, 5'b0} + {5'b0, bad_fin, 2'b0};
    thresh   = {9'b0, cl_seen_q[W-1:2]} + PW'(1);

    out_valid_d = out_valid_q && !out_ready_i;
    cls_d       = cls_q;
    bom_len_d   = bom_len_q;
    cnt_d       = cnt_q;
    if (do_close) begin
      out_valid_d = 1'b1;
      cnt_d       = bad_fin;
      bom_len_d   = ubsv_pkg::bom_len(cl_bom_q);
      unique case (cl_bom_q)
        ubsv_pkg::BOM_UTF8:    cls_d = ubsv_pkg::ENC_UTF8_BOM;
        ubsv_pkg::BOM_UTF16LE: cls_d = ubsv_pkg::ENC_UTF16LE_BOM;
        ubsv_pkg::BOM_UTF16BE: cls_d = ubsv_pkg::ENC_UTF16BE_BOM;
        default: cls_d = (prod < thresh) ? ubsv_pkg::ENC_UTF8 : ubsv_pkg::ENC_UNKNOWN;
      endcase
      bad_d     = '0;
      fill_d    = 2'd0;
      closing_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q      <= 2'd0;
      fill_q      <= 2'd0;
      rqn_q       <= 2'd0;
      bad_q       <= '0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      need_q      <= need_d;
      fill_q      <= fill_d;
      rqn_q       <= rqn_d;
      bad_q       <= bad_d;
      closing_q   <= closing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    rq_q      <= rq_d;
    cl_seen_q <= cl_seen_d;
    cl_bom_q  <= cl_bom_d;
    cls_q     <= cls_d;
    bom_len_q <= bom_len_d;
    cnt_q     <= cnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign encoding_class_o = cls_q;
  assign bom_length_o     = bom_len_q;
  assign invalid_count_o  = cnt_q;
  assign strict_valid_o   = cnt_q == '0;

endmodule

// ===== src/utf8_bom_stream_validator_unit.sv =====
// Top level of the UTF-8 / BOM stream validator: APB register, front end, queue, back end.
// Throughput: one byte beat per cycle while the queue has room; a failed multi-byte sequence
//   queues up to three bytes for replay, and each buffer end adds a close step in the back end.
// Result path: the last input beat passes the queue, the back end's closing flag and the output
//   register, behind any beats queued ahead of it and any replay due; the register holds it until taken.
// Reset: rst_ni (async, active low) clears per-buffer state and sets sample_limit to 4194304.
module utf8_bom_stream_validator_unit #(
  parameter int unsigned MAX_SAMPLE = ubsv_pkg::MaxSampleDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input byte channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_buffer_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    encoding_class_o,
  output logic [1:0]                    bom_length_o,
  output logic [ubsv_pkg::CountW-1:0]   invalid_count_o,
  output logic                          strict_valid_o,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ubsv_pkg::RegAddrW-1:0] paddr,
  input  logic [ubsv_pkg::RegDataW-1:0] pwdata,
  output logic [ubsv_pkg::RegDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned W = ubsv_pkg::CountW;

  logic [W-1:0]         sample_limit_q, sample_limit_d;
  ubsv_pkg::reg_index_e reg_idx;
  logic                 reg_wr;
  logic                 in_accept;
  ubsv_pkg::beat_t      front_beat, q_beat;
  logic                 q_valid, q_ready, q_pop;

  // ---- configuration register ----
  // Register index comes from the word address; low byte-lane bits are ignored.
  assign reg_idx = ubsv_pkg::reg_index_e'(paddr[ubsv_pkg::RegAddrW-1]);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    sample_limit_d = sample_limit_q;
    prdata         = '0;
    unique case (reg_idx)
      ubsv_pkg::REG_SAMPLE_LIMIT: begin
        prdata = {{(ubsv_pkg::RegDataW - W){1'b0}}, sample_limit_q};
        if (reg_wr) sample_limit_d = pwdata[W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_limit_q <= ubsv_pkg::SampleLimitReset;
    end else begin
      sample_limit_q <= sample_limit_d;
    end
  end

  // ---- front: sample window and BOM check; takes a beat whenever the queue has room ----
  assign in_ready_o = q_ready;
  assign in_accept  = in_valid_i && q_ready;

  ubsv_front #(
    .MAX_SAMPLE(MAX_SAMPLE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_limit_i (sample_limit_q),
    .data_byte_i    (data_byte_i),
    .end_of_buffer_i(end_of_buffer_i),
    .accept_i       (in_accept),
    .beat_o         (front_beat)
  );

  // ---- queue: lets the front keep taking beats while the back replays or waits ----
  ubsv_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_beat_i(front_beat),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .beat_o     (q_beat),
    .pop_i      (q_pop)
  );

  // ---- back: sequence checking, replay, counting and the result register ----
  ubsv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_beat_i        (q_beat),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .encoding_class_o(encoding_class_o),
    .bom_length_o    (bom_length_o),
    .invalid_count_o (invalid_count_o),
    .strict_valid_o  (strict_valid_o)
  );

endmodule

// ===== src/ubsv_checker.sv =====
// Port-level checks for the validator, bound to its top level.
module ubsv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [7:0]                    data_byte_i,
  input logic                          end_of_buffer_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [2:0]                    encoding_class_o,
  input logic [1:0]                    bom_length_o,
  input logic [ubsv_pkg::CountW-1:0]   invalid_count_o,
  input logic                          strict_valid_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ubsv_pkg::RegAddrW-1:0] paddr,
  input logic [ubsv_pkg::RegDataW-1:0] pwdata,
  input logic [ubsv_pkg::RegDataW-1:0] prdata,
  input logic                          pready
);

  localparam int unsigned W = ubsv_pkg::CountW;

  // input beat holds while stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(data_byte_i) &&
      $stable(end_of_buffer_i))
    else $error("input beat dropped or changed while stalled");

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(encoding_class_o) &&
      $stable(bom_length_o) && $stable(invalid_count_o) && $stable(strict_valid_o))
    else $error("result beat dropped or changed while stalled");

  a_strict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> strict_valid_o == (invalid_count_o == '0))
    else $error("strict_valid disagrees with invalid_count");

  a_bom_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((bom_length_o == ubsv_pkg::BomLenUtf8) ==
         (encoding_class_o == ubsv_pkg::ENC_UTF8_BOM)) &&
      ((bom_length_o == ubsv_pkg::BomLenUtf16) ==
         (encoding_class_o == ubsv_pkg::ENC_UTF16LE_BOM ||
          encoding_class_o == ubsv_pkg::ENC_UTF16BE_BOM)))
    else $error("bom_length disagrees with encoding_class");

  // a write to the limit register reads back, masked to its width
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[ubsv_pkg::RegAddrW-1] == 1'b0
      |=> (paddr[ubsv_pkg::RegAddrW-1] == 1'b0) |->
        prdata == {{(ubsv_pkg::RegDataW - W){1'b0}}, $past(pwdata[W-1:0])})
    else $error("sample_limit readback mismatch");

endmodule

bind utf8_bom_stream_validator_unit ubsv_checker u_ubsv_checker (.*);

// ===== dv/tb_utf8_bom_stream_validator_unit.sv =====
// Self-checking testbench for the UTF-8 / BOM stream validator top level.
`timescale 1ns / 100ps

module tb_utf8_bom_stream_validator_unit;

  // Clock, reset and all block inputs start at known values.
  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    data_byte_i     = 8'h00;
  logic                          end_of_buffer_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i     = 1'b0;
  logic [2:0]                    encoding_class_o;
  logic [1:0]                    bom_length_o;
  logic [ubsv_pkg::CountW-1:0]   invalid_count_o;
  logic                          strict_valid_o;
  logic                          psel            = 1'b0;
  logic                          penable         = 1'b0;
  logic                          pwrite          = 1'b0;
  logic [ubsv_pkg::RegAddrW-1:0] paddr           = '0;
  logic [ubsv_pkg::RegDataW-1:0] pwdata          = '0;
  logic [ubsv_pkg::RegDataW-1:0] prdata;
  logic                          pready;

  // When set, neither side inserts gaps or stalls.
  bit steady = 1'b0;
  int unsigned limit_writes = 0;
  int unsigned buffers_sent = 0;

  // Bytes of the buffer being built for the byte channel.
  logic [7:0] frame[$];

  typedef struct packed {
    ubsv_pkg::enc_class_e        cls;
    logic [1:0]                  bom;
    logic [ubsv_pkg::CountW-1:0] bad;
    logic                        clean;
  } verdict_t;

  // Tracks the per-buffer decoder state and the verdicts still owed by the block.
  class utf8_verdict_board;
    logic [7:0]                  seq_bytes[4];
    int unsigned                 seq_fill;
    int unsigned                 examined;
    int unsigned                 bad_bytes;
    logic [7:0]                  head[3];
    logic [ubsv_pkg::CountW-1:0] limit_reg;
    verdict_t                    due[$];
    int unsigned                 errors;
    int unsigned                 beats;
    int unsigned                 class_hits[5];

    function new();
      limit_reg = ubsv_pkg::SampleLimitReset;
      clear_buffer();
    endfunction

    function void clear_buffer();
      foreach (seq_bytes[i]) seq_bytes[i] = 8'h00;
      foreach (head[i]) head[i] = 8'h00;
      seq_fill  = 0;
      examined  = 0;
      bad_bytes = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    function int unsigned lead_len(logic [7:0] c);
      if (c >= ubsv_pkg::ByteLead2Lo && c <= ubsv_pkg::ByteLead2Hi) return 1;
      if (c >= ubsv_pkg::ByteLead3Lo && c <= ubsv_pkg::ByteLead3Hi) return 2;
      if (c >= ubsv_pkg::ByteLead4Lo && c <= ubsv_pkg::ByteLead4Hi) return 3;
      return 0;
    endfunction

    function void tally_bad();
      if (bad_bytes < 32'h7FFFFF) bad_bytes++;
    endfunction

    // Work list instead of recursion: a failed sequence puts its tail bytes
    // back at the front, so they are decoded as lead bytes before anything else.
    function void run_decoder(logic [7:0] first);
      logic [7:0]  work[$];
      logic [7:0]  c;
      logic [7:0]  lead;
      logic [7:0]  c1;
      int unsigned need;
      int          k;
      bit          ok;
      work.push_back(first);
      while (work.size() > 0) begin
        c = work.pop_front();
        if (seq_fill == 0) begin
          if (c < ubsv_pkg::ByteAsciiTop) continue;
          if (lead_len(c) == 0) begin
            tally_bad();
            continue;
          end
          seq_bytes[0] = c;
          seq_fill = 1;
          continue;
        end
        need = lead_len(seq_bytes[0]);
        seq_bytes[seq_fill] = c;
        seq_fill++;
        if (seq_fill < need + 1) continue;
        ok = 1'b1;
        for (k = 1; k <= need; k++)
          if (seq_bytes[k] < ubsv_pkg::ByteContLo || seq_bytes[k] > ubsv_pkg::ByteContHi)
            ok = 1'b0;
        lead = seq_bytes[0];
        c1   = seq_bytes[1];
        if (ok) begin
          // overlong
          if (need == 2 && lead == ubsv_pkg::ByteLead3Lo && c1 < ubsv_pkg::ByteE0Min)
            ok = 1'b0;
          // surrogate
          if (need == 2 && lead == ubsv_pkg::ByteSurrLead && c1 >= ubsv_pkg::ByteSurrMin)
            ok = 1'b0;
          // overlong
          if (need == 3 && lead == ubsv_pkg::ByteLead4Lo && c1 < ubsv_pkg::ByteF0Min)
            ok = 1'b0;
          // > U+10FFFF
          if (need == 3 && lead == ubsv_pkg::ByteLead4Hi && c1 > ubsv_pkg::ByteF4Max)
            ok = 1'b0;
        end
        seq_fill = 0;
        if (!ok) begin
          tally_bad();
          for (k = need; k >= 1; k--) work.push_front(seq_bytes[k]);
        end
      end
    endfunction

    // Called for every accepted input beat.
    function void take_byte(logic [7:0] b, logic last);
      int unsigned lim;
      verdict_t    v;
      lim = limit_reg;
      if (lim == 0) lim = 1;
      if (lim > ubsv_pkg::MaxSampleDefault) lim = ubsv_pkg::MaxSampleDefault;
      beats++;
      if (examined < lim) begin
        if (examined < 3) head[examined] = b;
        examined++;
        run_decoder(b);
      end
      if (!last) return;
      // sequence cut off by the end of the buffer
      if (seq_fill != 0) begin
        tally_bad();
        seq_fill = 0;
      end
      v.bom = ubsv_pkg::BomLenNone;
      if (examined >= 3 && head[0] == ubsv_pkg::BomEf && head[1] == ubsv_pkg::BomBb &&
          head[2] == ubsv_pkg::BomBf) begin
        v.cls = ubsv_pkg::ENC_UTF8_BOM;
        v.bom = ubsv_pkg::BomLenUtf8;
      end else if (examined >= 2 && head[0] == ubsv_pkg::BomFf &&
                   head[1] == ubsv_pkg::BomFe) begin
        v.cls = ubsv_pkg::ENC_UTF16LE_BOM;
        v.bom = ubsv_pkg::BomLenUtf16;
      end else if (examined >= 2 && head[0] == ubsv_pkg::BomFe &&
                   head[1] == ubsv_pkg::BomFf) begin
        v.cls = ubsv_pkg::ENC_UTF16BE_BOM;
        v.bom = ubsv_pkg::BomLenUtf16;
      end else if (longint'(bad_bytes) * 100 < longint'(examined / 4) + 1) begin
        v.cls = ubsv_pkg::ENC_UTF8;
      end else begin
        v.cls = ubsv_pkg::ENC_UNKNOWN;
      end
      v.bad   = bad_bytes[ubsv_pkg::CountW-1:0];
      v.clean = (bad_bytes == 0);
      due.push_back(v);
      clear_buffer();
    endfunction

    // Called for every accepted result beat.
    task check_verdict(logic [2:0] cls, logic [1:0] bom, logic [ubsv_pkg::CountW-1:0] bad,
                       logic clean);
      verdict_t v;
      if (due.size() == 0) begin
        report_mismatch("result beat with no buffer closed");
        return;
      end
      v = due.pop_front();
      class_hits[v.cls]++;
      if (cls !== v.cls)
        report_mismatch($sformatf("encoding_class got %0d want %0d", cls, v.cls));
      if (bom !== v.bom)
        report_mismatch($sformatf("bom_length got %0d want %0d", bom, v.bom));
      if (bad !== v.bad)
        report_mismatch($sformatf("invalid_count got %0d want %0d", bad, v.bad));
      if (clean !== v.clean)
        report_mismatch($sformatf("strict_valid got %0d want %0d", clean, v.clean));
    endtask
  endclass

  utf8_verdict_board sb = new();

  utf8_bom_stream_validator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .encoding_class_o(encoding_class_o),
    .bom_length_o    (bom_length_o),
    .invalid_count_o (invalid_count_o),
    .strict_valid_o  (strict_valid_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // Monitor both channels on pre-edge values; drive the result-side stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_byte(data_byte_i, end_of_buffer_i);
      if (out_valid_o && out_ready_i)
        sb.check_verdict(encoding_class_o, bom_length_o, invalid_count_o, strict_valid_o);
      out_ready_i <= steady || ($urandom_range(99) >= 14);
    end
  end

  function automatic logic [7:0] pick_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // Appends one character: mostly well-formed UTF-8, some noise and broken sequences.
  function automatic void add_char();
    int unsigned pick;
    logic [7:0]  lead;
    pick = $urandom_range(99);
    if (pick < 8) begin
      frame.push_back(pick_byte(0, 255));
    end else if (pick < 14) begin
      // lead byte followed by anything
      frame.push_back(pick_byte(ubsv_pkg::ByteLead2Lo, ubsv_pkg::ByteLead4Hi));
      frame.push_back(pick_byte(0, 255));
    end else if (pick < 45) begin
      frame.push_back(pick_byte(0, ubsv_pkg::ByteAsciiTop - 1));
    end else if (pick < 65) begin
      frame.push_back(pick_byte(ubsv_pkg::ByteLead2Lo, ubsv_pkg::ByteLead2Hi));
      frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteContHi));
    end else if (pick < 85) begin
      lead = pick_byte(ubsv_pkg::ByteLead3Lo, ubsv_pkg::ByteLead3Hi);
      frame.push_back(lead);
      if (lead == ubsv_pkg::ByteLead3Lo)
        frame.push_back(pick_byte(ubsv_pkg::ByteE0Min, ubsv_pkg::ByteContHi));
      else if (lead == ubsv_pkg::ByteSurrLead)
        frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteSurrMin - 1));
      else
        frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteContHi));
      frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteContHi));
    end else begin
      lead = pick_byte(ubsv_pkg::ByteLead4Lo, ubsv_pkg::ByteLead4Hi);
      frame.push_back(lead);
      if (lead == ubsv_pkg::ByteLead4Lo)
        frame.push_back(pick_byte(ubsv_pkg::ByteF0Min, ubsv_pkg::ByteContHi));
      else if (lead == ubsv_pkg::ByteLead4Hi)
        frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteF4Max));
      else
        frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteContHi));
      frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteContHi));
      frame.push_back(pick_byte(ubsv_pkg::ByteContLo, ubsv_pkg::ByteContHi));
    end
  endfunction

  // One input beat; valid stays up across back-to-back beats.
  task automatic send_beat(logic [7:0] b, logic last);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_buffer_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_frame(bit close);
    foreach (frame[i]) send_beat(frame[i], close && (i == frame.size() - 1));
    if (close) buffers_sent++;
  endtask

  // Random buffers until about budget bytes went out; a truncated tail
  // gives a cut-off sequence now and then.
  task automatic run_buffers(int unsigned budget, int unsigned max_len, int unsigned bom_pct);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(max_len, 1) : $urandom_range(12, 1);
      frame.delete();
      if ($urandom_range(99) < bom_pct) begin
        case ($urandom_range(2))
          0:       frame = '{ubsv_pkg::BomEf, ubsv_pkg::BomBb, ubsv_pkg::BomBf};
          1:       frame = '{ubsv_pkg::BomFf, ubsv_pkg::BomFe};
          default: frame = '{ubsv_pkg::BomFe, ubsv_pkg::BomFf};
        endcase
      end
      while (frame.size() < len) add_char();
      while (frame.size() > len) void'(frame.pop_back());
      send_frame(1'b1);
      sent += len;
    end
  endtask

  // Block is idle once every verdict is back and any replay has drained.
  task automatic settle();
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // APB write of sample_limit, then read back.
  task automatic set_sample_limit(logic [ubsv_pkg::RegDataW-1:0] value);
    logic [ubsv_pkg::RegDataW-1:0] got;
    in_valid_i <= 1'b0;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ubsv_pkg::REG_SAMPLE_LIMIT, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.limit_reg = value[ubsv_pkg::CountW-1:0];
    limit_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== ubsv_pkg::RegDataW'(value[ubsv_pkg::CountW-1:0]))
      sb.report_mismatch($sformatf("sample_limit read 0x%0h want 0x%0h", got,
                                   value[ubsv_pkg::CountW-1:0]));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Largest register value with junk above bit 22: clamps to the max sample.
    set_sample_limit(32'hA5FF_FFFF);

    // Directed: each BOM kind, BOM with a bad byte, single ASCII byte,
    // then overlong, surrogate, above-range, bad leads, bad continuation
    // and a sequence cut off by the end of the buffer.
    frame = '{8'hEF, 8'hBB, 8'hBF, 8'hC0};
    send_frame(1'b1);
    frame = '{8'hFF, 8'hFE};
    send_frame(1'b1);
    frame = '{8'hFE, 8'hFF};
    send_frame(1'b1);
    frame = '{8'h00};
    send_frame(1'b1);
    frame = '{8'hE0, 8'h9F, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF0, 8'h8F, 8'h80, 8'h80,
              8'hF4, 8'h90, 8'h80, 8'h80, 8'hC0, 8'hF5, 8'hFF, 8'hC2, 8'h41, 8'hE2,
              8'h82};
    send_frame(1'b1);
    run_buffers(90, 40, 15);

    // Zero limit behaves as one byte, then the real minimum.
    set_sample_limit(32'd0);
    run_buffers(40, 12, 20);
    set_sample_limit(32'd1);
    run_buffers(40, 12, 30);
    // Limits right at the BOM lengths.
    set_sample_limit(32'd2);
    run_buffers(30, 8, 60);
    set_sample_limit(32'd3);
    run_buffers(30, 8, 60);

    // Limit lowered below the bytes already taken in an open buffer.
    set_sample_limit(ubsv_pkg::RegDataW'(ubsv_pkg::SampleLimitReset));
    frame.delete();
    while (frame.size() < 10) add_char();
    send_frame(1'b0);
    set_sample_limit(32'd6);
    frame.delete();
    while (frame.size() < 5) add_char();
    send_frame(1'b1);

    // Long stretch with neither side idling.
    set_sample_limit(ubsv_pkg::RegDataW'(ubsv_pkg::SampleLimitReset));
    steady = 1'b1;
    run_buffers(130, 40, 15);
    steady = 1'b0;

    set_sample_limit(ubsv_pkg::RegDataW'($urandom_range(40, 4)));
    run_buffers(100, 40, 15);

    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d byte beats in %0d buffers over %0d sample_limit writes.",
             sb.beats, buffers_sent, limit_writes);
    $display("Verdicts: unknown %0d, UTF-8 BOM %0d, UTF-16LE %0d, UTF-16BE %0d, UTF-8 %0d.",
             sb.class_hits[0], sb.class_hits[1], sb.class_hits[2], sb.class_hits[3],
             sb.class_hits[4]);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("utf8_bom_stream_validator_unit test passed");
    end else begin
      $display("utf8_bom_stream_validator_unit test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("utf8_bom_stream_validator_unit test failed");
    $finish;
  end

endmodule
